// ----- src/life_automaton_row_stream_step_unit_assert.svh -----
// Assertion macros shared by the row-stream Life step unit.
`ifndef LIFE_AUTOMATON_ROW_STREAM_STEP_UNIT_ASSERT_SVH
`define LIFE_AUTOMATON_ROW_STREAM_STEP_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define LRSS_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lrss assertion failed");

// next-cycle implication
`define LRSS_ASSERT_NXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrss assertion failed");

`endif

// ----- src/lrss_pkg.sv -----
// Types and constants for the row-stream Life step unit.
package lrss_pkg;

	localparam int LRSS_ROW_CELLS = 64;
	localparam int LRSS_DATA_W    = 64;
	localparam int LRSS_IDX_W     = 16;
	localparam int LRSS_GW_W      = 7;
	localparam logic [LRSS_GW_W-1:0] LRSS_GW_RESET = 7'd64;

	localparam int LRSS_OUT_DEPTH = 4;
	localparam int LRSS_PTR_W     = $clog2(LRSS_OUT_DEPTH);
	localparam int LRSS_LVL_W     = LRSS_PTR_W + 1;

	typedef struct packed {
		logic [LRSS_DATA_W-1:0] cells;
		logic [LRSS_IDX_W-1:0]  idx;
		logic                   last;
	} res_beat_t;

	typedef struct packed {
		logic load;     // shift the row window down by one
		logic clear;    // frame over, back to empty
		logic compute;  // two rows held: interior columns evolve
	} cell_ctrl_t;

	typedef struct packed {
		logic en_a;     // computed row above
		logic en_b;     // last row, unchanged
	} fifo_push_t;

endpackage

// ----- src/life_automaton_row_stream_step_unit.sv -----
// Top level of the row-stream Life (B3/S23) step unit.
// One generation of Conway's Life on a grid fed one row per input beat,
// row 0 first, last_row on the final row. A row of column cells holds the
// two previous rows; each cell shifts its bits down on each accepted row
// but the last, and evaluates its column of the arriving row's upper
// neighbour in the same cycle. One input beat is taken every clock unless
// in_stall is high: the cell row finishes a row in the cycle it is
// accepted and pushes its result into a four-beat output queue, whose
// head is shown on the output. The final row of a frame yields two beats
// (the row above, then the last row itself with frame_end set), so
// in_stall rises while the queue holds more than two beats; with the
// output side free the unit sustains one row per cycle. The first row of
// a frame yields nothing, the second yields row 0 unchanged. Edge rows
// and columns pass through, bits at and above min(grid_width, ROW_CELLS)
// read as zero, and row_index saturates at 65535. grid_width resets to
// 64; the user writes it via cfg_wr_en/cfg_wr_data only while idle,
// which the unit does not enforce. No clearing pass is needed after reset.
module life_automaton_row_stream_step_unit #(
	parameter int ROW_CELLS = lrss_pkg::LRSS_ROW_CELLS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [lrss_pkg::LRSS_GW_W-1:0]  cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lrss_pkg::LRSS_DATA_W-1:0] row_cells,
	input  logic                            last_row,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lrss_pkg::LRSS_DATA_W-1:0] next_cells,
	output logic [lrss_pkg::LRSS_IDX_W-1:0] row_index,
	output logic                            frame_end
);
	import lrss_pkg::*;
	`include "life_automaton_row_stream_step_unit_assert.svh"

	localparam logic [LRSS_GW_W-1:0] ROW_CELLS_W = LRSS_GW_W'(ROW_CELLS);
	localparam logic [LRSS_LVL_W-1:0] STALL_LVL  = LRSS_LVL_W'(LRSS_OUT_DEPTH - 2);
	localparam logic [LRSS_IDX_W-1:0] IDX_MAX    = '1;

	logic [LRSS_GW_W-1:0]  grid_width_q;
	logic [LRSS_IDX_W-1:0] rows_seen_q;
	logic [LRSS_GW_W-1:0]  w_eff;
	logic                  in_acc;
	logic                  pop;

	cell_ctrl_t            ctrl;
	fifo_push_t            push;
	res_beat_t             beat_a;
	res_beat_t             beat_b;
	res_beat_t             head;
	logic [LRSS_LVL_W-1:0] level;

	logic [ROW_CELLS-1:0]  cur_row;
	logic [ROW_CELLS-1:0]  up_row;
	logic [ROW_CELLS-1:0]  mid_row;
	logic [ROW_CELLS-1:0]  nxt_row;
	logic [ROW_CELLS+1:0]  cur_pad;
	logic [ROW_CELLS+1:0]  up_pad;
	logic [ROW_CELLS+1:0]  mid_pad;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			grid_width_q <= LRSS_GW_RESET;
		else if (cfg_wr_en)
			grid_width_q <= cfg_wr_data;
	end

	assign w_eff = (grid_width_q > ROW_CELLS_W) ? ROW_CELLS_W : grid_width_q;

	// handshakes: stall only when a two-beat push might not fit
	assign in_stall  = (level > STALL_LVL);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (level != '0);
	assign pop       = out_valid && !out_stall;

	// frame position, saturating
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rows_seen_q <= '0;
		else if (in_acc) begin
			if (last_row)
				rows_seen_q <= '0;
			else if (rows_seen_q != IDX_MAX)
				rows_seen_q <= rows_seen_q + LRSS_IDX_W'(1);
		end
	end

	assign ctrl.load    = in_acc && !last_row;
	assign ctrl.clear   = in_acc && last_row;
	assign ctrl.compute = (rows_seen_q > LRSS_IDX_W'(1));

	// neighbours beyond the edges read as dead
	assign cur_pad = {1'b0, cur_row, 1'b0};
	assign up_pad  = {1'b0, up_row, 1'b0};
	assign mid_pad = {1'b0, mid_row, 1'b0};

	for (genvar x = 0; x < ROW_CELLS; x++) begin : g_col
		localparam logic [LRSS_GW_W:0] COL = (LRSS_GW_W + 1)'(x);
		logic col_on;
		logic col_inner;

		assign col_on    = ({1'b0, w_eff} > COL);
		assign col_inner = (COL != '0) && ({1'b0, w_eff} > (COL + (LRSS_GW_W + 1)'(1)));
		assign cur_row[x] = row_cells[x] && col_on;

		lrss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.col_on    (col_on),
			.col_inner (col_inner),
			.cur       (cur_row[x]),
			.up_l      (up_pad[x]),
			.up_r      (up_pad[x+2]),
			.mid_l     (mid_pad[x]),
			.mid_r     (mid_pad[x+2]),
			.dn_l      (cur_pad[x]),
			.dn_r      (cur_pad[x+2]),
			.up        (up_row[x]),
			.mid       (mid_row[x]),
			.nxt       (nxt_row[x])
		);
	end

	// result beats: the row above, and on the last row the row itself
	always_comb begin
		beat_a                       = '0;
		beat_a.cells[ROW_CELLS-1:0]  = nxt_row;
		beat_a.idx                   = rows_seen_q - LRSS_IDX_W'(1);
		beat_a.last                  = 1'b0;
		beat_b                       = '0;
		beat_b.cells[ROW_CELLS-1:0]  = cur_row;
		beat_b.idx                   = rows_seen_q;
		beat_b.last                  = 1'b1;
	end

	assign push.en_a = in_acc && (rows_seen_q != '0);
	assign push.en_b = in_acc && last_row;

	lrss_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.beat_a (beat_a),
		.beat_b (beat_b),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	assign next_cells = head.cells;
	assign row_index  = head.idx;
	assign frame_end  = head.last;

	// queue never fills past its depth
	`LRSS_ASSERT_IMP(a_level_bound, 1'b1, level <= LRSS_LVL_W'(LRSS_OUT_DEPTH))
	// an accepted beat always has room for two results
	`LRSS_ASSERT_IMP(a_acc_room, in_acc, level <= STALL_LVL)
	// last row ends the frame
	`LRSS_ASSERT_NXT(a_frame_restart, in_acc && last_row, rows_seen_q == '0)
	// last row always leaves a result waiting
	`LRSS_ASSERT_NXT(a_last_pending, in_acc && last_row, out_valid)

endmodule

// ----- src/lrss_cell.sv -----
// One column of the Life row window: two stored bits and the B3/S23 rule.
module lrss_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lrss_pkg::cell_ctrl_t ctrl,
	input  logic               col_on,
	input  logic               col_inner,
	input  logic               cur,
	input  logic               up_l,
	input  logic               up_r,
	input  logic               mid_l,
	input  logic               mid_r,
	input  logic               dn_l,
	input  logic               dn_r,
	output logic               up,
	output logic               mid,
	output logic               nxt
);
	import lrss_pkg::*;

	logic       up_q;
	logic       mid_q;
	logic [3:0] n;
	logic       life;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_q  <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctrl.clear) begin
			up_q  <= 1'b0;
			mid_q <= 1'b0;
		end else if (ctrl.load) begin
			up_q  <= mid_q;
			mid_q <= cur;
		end
	end

	always_comb begin
		n = 4'(up_l) + 4'(up_q) + 4'(up_r) + 4'(mid_l) + 4'(mid_r)
		  + 4'(dn_l) + 4'(cur) + 4'(dn_r);
		life = (n == 4'd3) || ((n == 4'd2) && mid_q);
		if (!col_on)
			nxt = 1'b0;
		else if (ctrl.compute && col_inner)
			nxt = life;
		else
			nxt = mid_q;
	end

	assign up  = up_q;
	assign mid = mid_q;

endmodule

// ----- src/lrss_out_fifo.sv -----
// Result queue: takes up to two beats a cycle, hands out one.
module lrss_out_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lrss_pkg::fifo_push_t            push,
	input  lrss_pkg::res_beat_t             beat_a,
	input  lrss_pkg::res_beat_t             beat_b,
	input  logic                            pop,
	output lrss_pkg::res_beat_t             head,
	output logic [lrss_pkg::LRSS_LVL_W-1:0] level
);
	import lrss_pkg::*;

	res_beat_t               mem_q [LRSS_OUT_DEPTH];
	logic [LRSS_PTR_W-1:0]   wr_ptr_q;
	logic [LRSS_PTR_W-1:0]   rd_ptr_q;
	logic [LRSS_LVL_W-1:0]   level_q;
	logic [LRSS_LVL_W-1:0]   n_push;
	logic [LRSS_PTR_W-1:0]   b_ptr;

	assign n_push = LRSS_LVL_W'(push.en_a) + LRSS_LVL_W'(push.en_b);
	// b follows a when both go in this cycle
	assign b_ptr  = push.en_a ? (wr_ptr_q + LRSS_PTR_W'(1)) : wr_ptr_q;

	always_ff @(posedge clk) begin
		if (push.en_a)
			mem_q[wr_ptr_q] <= beat_a;
		if (push.en_b)
			mem_q[b_ptr] <= beat_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[LRSS_PTR_W-1:0];
			rd_ptr_q <= rd_ptr_q + LRSS_PTR_W'(pop);
			level_q  <= level_q + n_push - LRSS_LVL_W'(pop);
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign level = level_q;

endmodule
